@@ hw/rtl/irdig_pkg.sv @@
// ----------------------------------------------------------------------------
// irdig_pkg
// Shared types, constants and helpers of the radix digit converter.
// ----------------------------------------------------------------------------
package irdig_pkg;

   localparam int unsigned NUMBER_WIDTH_DEFAULT = 64;
   localparam int unsigned RADIX_WIDTH          = 8;
   localparam int unsigned CHAR_WIDTH           = 7;
   localparam int unsigned STATUS_WIDTH         = 2;
   localparam int unsigned DIGIT_WIDTH          = 6;
   localparam int unsigned MIN_RADIX            = 2;
   localparam int unsigned MAX_RADIX            = 61;
   localparam int unsigned QUEUE_DEPTH          = 2;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_OK   = 2'd0,
      STATUS_LOW  = 2'd1,
      STATUS_HIGH = 2'd2
   } status_type;

   // Classified job handed from front to back.
   typedef enum logic [1:0] {
      JOB_CONVERT = 2'd0,
      JOB_SINGLE  = 2'd1
   } job_kind_type;

   typedef enum logic [1:0] {
      BE_IDLE   = 2'd0,
      BE_DIVIDE = 2'd1,
      BE_EMIT   = 2'd2
   } be_state_type;

   // Map a digit value (0..60) to its ASCII code.
   function automatic logic [CHAR_WIDTH-1:0] digit_to_ascii(input logic [DIGIT_WIDTH-1:0] d);
      logic [CHAR_WIDTH-1:0] r;
      if (d < 6'd10)
         r = 7'h30 + {1'b0, d};
      else if (d < 6'd36)
         r = 7'h41 + {1'b0, d} - 7'd10;
      else
         r = 7'h61 + {1'b0, d} - 7'd36;
      return r;
   endfunction

endpackage

@@ hw/rtl/irdig_if.sv @@
// ----------------------------------------------------------------------------
// irdig_req_if / irdig_rsp_if
// Valid/ready channels for conversion requests and digit responses.
// ----------------------------------------------------------------------------
interface irdig_req_if #(parameter int unsigned NUMBER_WIDTH = 64);
   logic                    valid;
   logic                    ready;
   logic [NUMBER_WIDTH-1:0] number;
   logic [7:0]              radix;
   modport source (output valid, number, radix, input ready);
   modport sink   (input valid, number, radix, output ready);
endinterface

interface irdig_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] digit_char;
   logic [1:0] status;
   logic       no_digits;
   logic       last;
   modport source (output valid, digit_char, status, no_digits, last, input ready);
   modport sink   (input valid, digit_char, status, no_digits, last, output ready);
endinterface

@@ hw/rtl/irdig_front.sv @@
// ----------------------------------------------------------------------------
// irdig_front
// Accepts requests, checks the base and pushes classified jobs into a
// two-entry queue toward the conversion engine.
// ----------------------------------------------------------------------------
module irdig_front #(
   parameter int unsigned NUMBER_WIDTH = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   irdig_req_if.sink                         req,
   output logic                              job_valid,
   input  logic                              job_pop,
   output irdig_pkg::job_kind_type           job_kind,
   output logic [NUMBER_WIDTH-1:0]           job_number,
   output logic [irdig_pkg::RADIX_WIDTH-1:0] job_radix,
   output irdig_pkg::status_type             job_status,
   output logic                              job_no_digits
);
   import irdig_pkg::*;

   typedef struct packed {
      job_kind_type            kind;
      logic [NUMBER_WIDTH-1:0] number;
      logic [RADIX_WIDTH-1:0]  radix;
      status_type              status;
      logic                    no_digits;
   } job_type;

   job_type    q_ff [QUEUE_DEPTH];
   job_type    q_in [QUEUE_DEPTH];
   logic [1:0] count_ff, count_in;
   job_type    new_job;
   logic       push;

   // Classify the incoming transaction
   always_comb begin
      new_job.number    = req.number;
      new_job.radix     = req.radix;
      new_job.kind      = JOB_SINGLE;
      new_job.status    = STATUS_OK;
      new_job.no_digits = 1'b0;
      if (req.radix < RADIX_WIDTH'(MIN_RADIX))
         new_job.status = STATUS_LOW;
      else if (req.radix > RADIX_WIDTH'(MAX_RADIX))
         new_job.status = STATUS_HIGH;
      else if (req.number == '0)
         new_job.no_digits = 1'b1;
      else
         new_job.kind = JOB_CONVERT;
   end

   assign req.ready = (count_ff != 2'd2);
   assign push      = req.valid && req.ready;

   // Queue: entry 0 is the head
   always_comb begin
      q_in     = q_ff;
      count_in = count_ff;
      if (job_pop) begin
         q_in[0]  = q_ff[1];
         count_in = count_in - 2'd1;
      end
      if (push) begin
         q_in[count_in[0]] = new_job;
         count_in = count_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset)
         count_ff <= '0;
      else
         count_ff <= count_in;
   end

   assign job_valid     = (count_ff != 2'd0);
   assign job_kind      = q_ff[0].kind;
   assign job_number    = q_ff[0].number;
   assign job_radix     = q_ff[0].radix;
   assign job_status    = q_ff[0].status;
   assign job_no_digits = q_ff[0].no_digits;

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2) else $error("queue count out of range");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> job_valid) else $error("pop from empty queue");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !job_pop) |=> count_ff == $past(count_ff) + 2'd1)
      else $error("queue count did not advance");
`endif
endmodule

@@ hw/rtl/irdig_back.sv @@
// ----------------------------------------------------------------------------
// irdig_back
// Conversion engine: restoring divider one quotient bit per cycle, digits
// kept in a shift-register stack, then emitted most significant first.
// ----------------------------------------------------------------------------
module irdig_back #(
   parameter int unsigned NUMBER_WIDTH = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              job_valid,
   output logic                              job_pop,
   input  irdig_pkg::job_kind_type           job_kind,
   input  logic [NUMBER_WIDTH-1:0]           job_number,
   input  logic [irdig_pkg::RADIX_WIDTH-1:0] job_radix,
   input  irdig_pkg::status_type             job_status,
   input  logic                              job_no_digits,
   irdig_rsp_if.source                       rsp
);
   import irdig_pkg::*;

   localparam int unsigned BIT_CNT_W = $clog2(NUMBER_WIDTH);
   localparam int unsigned DIG_CNT_W = $clog2(NUMBER_WIDTH + 1);

   be_state_type           state_ff, state_in;
   logic [NUMBER_WIDTH-1:0] quot_ff, quot_in;
   logic [RADIX_WIDTH-1:0]  rem_ff, rem_in;
   logic [RADIX_WIDTH-1:0]  radix_ff, radix_in;
   logic [BIT_CNT_W-1:0]    bit_ff, bit_in;
   logic [DIG_CNT_W-1:0]    ndig_ff, ndig_in;
   logic [DIGIT_WIDTH-1:0]  dig_ff [NUMBER_WIDTH];
   logic                    dig_we;
   logic                    dig_pop;

   logic                    ov_ff, ov_in;
   logic [CHAR_WIDTH-1:0]   och_ff, och_in;
   status_type              ost_ff, ost_in;
   logic                    ond_ff, ond_in;
   logic                    olast_ff, olast_in;

   logic [RADIX_WIDTH:0]    trial;
   logic [RADIX_WIDTH:0]    diff;
   logic                    out_free;
   logic [NUMBER_WIDTH-1:0] quot_next;
   logic [RADIX_WIDTH-1:0]  rem_next;

   assign out_free = !ov_ff || rsp.ready;

   // One restoring division step
   always_comb begin
      trial     = {rem_ff, quot_ff[NUMBER_WIDTH-1]};
      diff      = trial - {1'b0, radix_ff};
      quot_next = {quot_ff[NUMBER_WIDTH-2:0], ~diff[RADIX_WIDTH]};
      rem_next  = diff[RADIX_WIDTH] ? trial[RADIX_WIDTH-1:0] : diff[RADIX_WIDTH-1:0];
   end

   // Next state and outputs
   always_comb begin
      state_in = state_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      radix_in = radix_ff;
      bit_in   = bit_ff;
      ndig_in  = ndig_ff;
      dig_we   = 1'b0;
      dig_pop  = 1'b0;
      job_pop  = 1'b0;
      ov_in    = ov_ff && !rsp.ready;
      och_in   = och_ff;
      ost_in   = ost_ff;
      ond_in   = ond_ff;
      olast_in = olast_ff;
      case (state_ff)
         BE_IDLE: begin
            if (job_valid) begin
               if (job_kind == JOB_SINGLE) begin
                  if (out_free) begin
                     job_pop  = 1'b1;
                     ov_in    = 1'b1;
                     och_in   = '0;
                     ost_in   = job_status;
                     ond_in   = job_no_digits;
                     olast_in = 1'b1;
                  end
               end else begin
                  job_pop  = 1'b1;
                  quot_in  = job_number;
                  radix_in = job_radix;
                  rem_in   = '0;
                  bit_in   = '0;
                  ndig_in  = '0;
                  state_in = BE_DIVIDE;
               end
            end
         end
         BE_DIVIDE: begin
            quot_in = quot_next;
            rem_in  = rem_next;
            bit_in  = bit_ff + 1'b1;
            if (bit_ff == BIT_CNT_W'(NUMBER_WIDTH - 1)) begin
               dig_we  = 1'b1;
               ndig_in = ndig_ff + 1'b1;
               rem_in  = '0;
               bit_in  = '0;
               if (quot_next == '0)
                  state_in = BE_EMIT;
            end
         end
         BE_EMIT: begin
            if (out_free) begin
               dig_pop  = 1'b1;
               ov_in    = 1'b1;
               och_in   = digit_to_ascii(dig_ff[0]);
               ost_in   = STATUS_OK;
               ond_in   = 1'b0;
               olast_in = (ndig_ff == DIG_CNT_W'(1));
               ndig_in  = ndig_ff - 1'b1;
               if (ndig_ff == DIG_CNT_W'(1))
                  state_in = BE_IDLE;
            end
         end
         default: state_in = BE_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
      radix_ff <= radix_in;
      bit_ff   <= bit_in;
      och_ff   <= och_in;
      ost_ff   <= ost_in;
      ond_ff   <= ond_in;
      olast_ff <= olast_in;
      // Digit stack: push at the top, newest (most significant) digit at entry 0
      if (dig_we) begin
         dig_ff[0] <= rem_next[DIGIT_WIDTH-1:0];
         for (int i = 1; i < NUMBER_WIDTH; i++)
            dig_ff[i] <= dig_ff[i-1];
      end else if (dig_pop) begin
         for (int i = 0; i < NUMBER_WIDTH - 1; i++)
            dig_ff[i] <= dig_ff[i+1];
      end
      if (reset) begin
         state_ff <= BE_IDLE;
         ndig_ff  <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ndig_ff  <= ndig_in;
         ov_ff    <= ov_in;
      end
   end

   assign rsp.valid      = ov_ff;
   assign rsp.digit_char = och_ff;
   assign rsp.status     = ost_ff;
   assign rsp.no_digits  = ond_ff;
   assign rsp.last       = olast_ff;

`ifndef SYNTHESIS
   a_emit_has_digits: assert property (@(posedge clock) disable iff (reset)
      state_ff == BE_EMIT |-> ndig_ff != '0) else $error("emit with no digits");
   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (ov_ff && !rsp.ready) |=> ov_ff && $stable(och_ff))
      else $error("stalled response changed");
   a_radix_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == BE_DIVIDE |-> radix_ff >= RADIX_WIDTH'(MIN_RADIX))
      else $error("bad radix in divider");
`endif
endmodule

@@ hw/rtl/integer_to_radix_digits.sv @@
// Flow: the engine takes a job from the queue, the restoring divider works
// out each digit, then the digits are emitted as the response side accepts them.
// A new job is taken only when the engine is idle; a bad base or zero gives
// one response, registered when the queue hands the job over.
// Reset: synchronous, active high; clears the queue and the engine state.
// ----------------------------------------------------------------------------
// integer_to_radix_digits
// Converts an unsigned number to ASCII digits, most significant first.
// ----------------------------------------------------------------------------
module integer_to_radix_digits #(
   parameter int unsigned NUMBER_WIDTH = irdig_pkg::NUMBER_WIDTH_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   irdig_req_if.sink   req,
   irdig_rsp_if.source rsp
);
   import irdig_pkg::*;

   logic                   job_valid;
   logic                   job_pop;
   job_kind_type           job_kind;
   logic [NUMBER_WIDTH-1:0] job_number;
   logic [RADIX_WIDTH-1:0] job_radix;
   status_type             job_status;
   logic                   job_no_digits;

   irdig_front #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_front (
      .clock, .reset, .req,
      .job_valid, .job_pop, .job_kind, .job_number, .job_radix,
      .job_status, .job_no_digits
   );

   irdig_back #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_back (
      .clock, .reset,
      .job_valid, .job_pop, .job_kind, .job_number, .job_radix,
      .job_status, .job_no_digits, .rsp
   );
endmodule

@@ bench/irdig_checker.sv @@
// ----------------------------------------------------------------------------
// irdig_checker
// Watches the request and response channels of the radix digit converter.
// It predicts the digit string for each accepted request and compares every
// response transaction with the oldest expected digit.
// ----------------------------------------------------------------------------
module irdig_checker
   import irdig_pkg::*;
#(
   parameter int unsigned NUMBER_WIDTH = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic [NUMBER_WIDTH-1:0] req_number,
   input  logic [7:0]              req_radix,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic [6:0]              rsp_digit_char,
   input  logic [1:0]              rsp_status,
   input  logic                    rsp_no_digits,
   input  logic                    rsp_last,
   output int                      fail_count,
   output int                      pending
);

   typedef struct packed {
      logic [6:0] digit_char;
      status_type status;
      logic       no_digits;
      logic       last;
   } digit_rsp_type;

   digit_rsp_type expected_digits[$];

   // ASCII code of one digit value
   function automatic logic [6:0] ascii_of_digit(input logic [5:0] d);
      logic [6:0] code;
      if (d < 10)
         code = 7'(8'h30 + d);
      else if (d < 36)
         code = 7'(8'h41 + d - 10);
      else
         code = 7'(8'h61 + d - 36);
      return code;
   endfunction

   // Queue the digit string expected for one request
   function automatic void predict_digits(input logic [NUMBER_WIDTH-1:0] number,
                                          input logic [7:0] radix);
      logic [63:0]   value;
      logic [5:0]    digits[$];
      digit_rsp_type item;
      value = 64'(number);
      if (radix < MIN_RADIX) begin
         expected_digits.push_back('{7'd0, STATUS_LOW, 1'b0, 1'b1});
      end else if (radix > MAX_RADIX) begin
         expected_digits.push_back('{7'd0, STATUS_HIGH, 1'b0, 1'b1});
      end else if (value == 0) begin
         expected_digits.push_back('{7'd0, STATUS_OK, 1'b1, 1'b1});
      end else begin
         // least significant first, emitted in reverse
         while (value != 0) begin
            digits.push_front(6'(value % radix));
            value = value / radix;
         end
         foreach (digits[i]) begin
            item = '{ascii_of_digit(digits[i]), STATUS_OK, 1'b0,
                     i == digits.size() - 1};
            expected_digits.push_back(item);
         end
      end
   endfunction

   // Predict on request transactions, compare on response transactions
   always @(posedge clock) begin
      digit_rsp_type want;
      if (reset) begin
         expected_digits.delete();
      end else begin
         if (req_valid && req_ready)
            predict_digits(req_number, req_radix);
         if (rsp_valid && rsp_ready) begin
            if (expected_digits.size() == 0) begin
               $display("%0t: unexpected response char=%0h status=%0d nd=%0b last=%0b",
                        $time, rsp_digit_char, rsp_status, rsp_no_digits, rsp_last);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_digits.pop_front();
               if (want.digit_char !== rsp_digit_char || want.status !== rsp_status ||
                   want.no_digits !== rsp_no_digits || want.last !== rsp_last) begin
                  $display("%0t: mismatch expected char=%0h status=%0d nd=%0b last=%0b",
                           $time, want.digit_char, want.status, want.no_digits,
                           want.last);
                  $display("%0t:          actual   char=%0h status=%0d nd=%0b last=%0b",
                           $time, rsp_digit_char, rsp_status, rsp_no_digits, rsp_last);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      // Outstanding count after this edge's transactions
      pending <= expected_digits.size();
   end

   initial fail_count = 0;
   initial pending = 0;

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Top of the radix digit converter bench: drives requests with random gaps,
// throttles the response side, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb;
   import irdig_pkg::*;

   localparam int unsigned NW        = 64;
   localparam int          MAX_CYCLE = 10000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending;
   int   cycle_count = 0;
   int   rsp_seen = 0;

   irdig_req_if #(.NUMBER_WIDTH(NW)) req_ch ();
   irdig_rsp_if                      rsp_ch ();

   integer_to_radix_digits #(.NUMBER_WIDTH(NW)) u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   irdig_checker #(.NUMBER_WIDTH(NW)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_ch.valid),
      .req_ready      (req_ch.ready),
      .req_number     (req_ch.number),
      .req_radix      (req_ch.radix),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .rsp_digit_char (rsp_ch.digit_char),
      .rsp_status     (rsp_ch.status),
      .rsp_no_digits  (rsp_ch.no_digits),
      .rsp_last       (rsp_ch.last),
      .fail_count     (fail_count),
      .pending        (pending)
   );

   always #6 clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MAX_CYCLE) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Short gaps mostly, a few long ones
   function automatic int gap_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Offer one request and hold it until the transaction completes
   task automatic send_request(input logic [NW-1:0] number, input logic [7:0] radix);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.number <= number;
      req_ch.radix  <= radix;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // Response side: random stalls, one long hold-off mid-run
   initial begin
      int  gap;
      bit  long_done;
      long_done = 0;
      rsp_ch.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!long_done && rsp_seen > 60) begin
            long_done = 1;
            rsp_ch.ready <= 1'b0;
            repeat (500) @(posedge clock);
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : gap_length();
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) rsp_seen++;
      end
   end

   // Stimulus and verdict
   initial begin
      logic [NW-1:0] number;
      logic [7:0]    radix;
      int            roll;
      req_ch.valid  = 1'b0;
      req_ch.number = '0;
      req_ch.radix  = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: bad bases, zero, extremes, digits from all three symbol ranges
      send_request({NW{1'b1}}, 8'd0);
      send_request(64'd5, 8'd1);
      send_request(64'd5, 8'd62);
      send_request({NW{1'b1}}, 8'd255);
      send_request(64'd0, 8'd0);
      send_request(64'd0, 8'd10);
      send_request(64'd0, 8'd2);
      send_request({NW{1'b1}}, 8'd2);
      send_request({NW{1'b1}}, 8'd61);
      send_request({NW{1'b1}}, 8'd10);
      send_request(64'd1, 8'd2);
      send_request(64'd60, 8'd61);
      send_request(64'd35, 8'd36);
      send_request(64'd123456789, 8'd10);
      send_request(64'hDEADBEEFCAFEF00D, 8'd16);
      for (int d = 0; d < 61; d += 7)
         send_request(64'(d * 61 * 61 + (d + 3) * 61 + d + 5), 8'd61);
      send_request(64'h8000000000000000, 8'd3);
      send_request(64'd61, 8'd61);

      // Let everything drain before the random part
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);

      // Random requests: mostly valid bases with numbers of random size
      for (int i = 0; i < 84; i++) begin
         roll = $urandom_range(0, 99);
         number = {$urandom, $urandom} >> $urandom_range(0, 63);
         if (roll < 5) number = '0;
         if (roll < 85)
            radix = 8'($urandom_range(MIN_RADIX, MAX_RADIX));
         else
            radix = 8'($urandom_range(0, 255));
         send_request(number, radix);
      end
      req_ch.valid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
